>>> rtl/u8dec_pkg.sv
// Shared types and constants for the lenient UTF-8 decoder.
package u8dec_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int PEND_W  = 2;
  localparam int CONT_W  = 6;

  typedef struct packed {
    logic [PEND_W-1:0] bytes_pending;
    logic [CP_W-1:0]   partial_value;
  } dec_state_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            has_char;
    logic            string_end;
  } char_beat_t;

  typedef struct packed {
    logic       valid;
    char_beat_t beat;
  } dec_result_t;

endpackage

>>> rtl/u8dec_if.sv
// Byte and character channel interfaces for the UTF-8 decoder.
interface u8dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source(output valid, byte_value, last_byte, input ready);
  modport sink(input valid, byte_value, last_byte, output ready);
endinterface

interface u8dec_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        has_char;
  logic        string_end;

  modport source(output valid, code_point, has_char, string_end, input ready);
  modport sink(input valid, code_point, has_char, string_end, output ready);
endinterface

>>> rtl/u8dec_decode.sv
// Sequence state and per-byte decode logic.
module u8dec_decode (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [u8dec_pkg::BYTE_W-1:0]   byte_value,
  input  logic                           last_byte,
  output u8dec_pkg::dec_result_t         res
);
  import u8dec_pkg::*;

  dec_state_t state;
  dec_state_t state_next;

  always_comb begin
    dec_state_t  s;
    dec_result_t r;
    s = state;
    r = '0;
    if (state.bytes_pending != '0) begin
      s.partial_value = {state.partial_value[CP_W-CONT_W-1:0], byte_value[CONT_W-1:0]};
      s.bytes_pending = state.bytes_pending - PEND_W'(1);
      if (s.bytes_pending == '0) begin
        r.valid           = 1'b1;
        r.beat.code_point = s.partial_value;
        r.beat.has_char   = 1'b1;
        r.beat.string_end = last_byte;
        s.partial_value   = '0;
      end
    end else if (!byte_value[7]) begin
      r.valid           = 1'b1;
      r.beat.code_point = CP_W'(byte_value);
      r.beat.has_char   = 1'b1;
      r.beat.string_end = last_byte;
    end else if (!byte_value[6]) begin
      // lone continuation byte: dropped
    end else if (!byte_value[5]) begin
      s.partial_value = CP_W'(byte_value[4:0]);
      s.bytes_pending = PEND_W'(1);
    end else if (!byte_value[4]) begin
      s.partial_value = CP_W'(byte_value[3:0]);
      s.bytes_pending = PEND_W'(2);
    end else begin
      s.partial_value = CP_W'(byte_value[2:0]);
      s.bytes_pending = PEND_W'(3);
    end

    if (last_byte && !r.valid) begin
      s                 = '0;
      r.valid           = 1'b1;
      r.beat.code_point = '0;
      r.beat.has_char   = 1'b0;
      r.beat.string_end = 1'b1;
    end
    state_next = s;
    res        = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  a_idle_no_bits: assert property (@(posedge clk) disable iff (rst)
    state.bytes_pending == '0 |-> state.partial_value == '0)
    else $error("partial bits held with no sequence open");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> state == '0)
    else $error("state not cleared after last byte");

  a_end_only: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && !res.beat.has_char |->
      res.beat.string_end && res.beat.code_point == '0)
    else $error("empty result not an end marker");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |-> res.valid && res.beat.string_end)
    else $error("last byte gave no closing result");

endmodule

>>> rtl/utf8_lenient_decoder_core.sv
// Lenient UTF-8 decoder: one byte beat in, at most one code point beat out.
//
// The bytes channel takes one byte of a string per beat, with last_byte set
// on the final byte. The chars channel gives one beat per completed
// character (has_char set), and a closing beat with only string_end set
// when the last byte completes no character. Lone continuation bytes and
// sequences cut off by the end of a string are dropped.
//
// A taken byte is held in the input register; its decode result is
// captured in the output register when the byte moves on, and is offered
// from there until it is taken. One byte is taken every cycle while the
// output is not stalled; the sequence state is updated in the same
// cycle as the result register.
//
// When chars.ready is low the output register holds its beat, the input
// register fills, and bytes.ready drops until the output beat is taken.
// Reset clears the valid flags of both registers and the sequence state,
// so decoding starts at a fresh string.
module utf8_lenient_decoder_core (
  input logic         clk,
  input logic         rst,
  u8dec_in_if.sink    bytes,
  u8dec_out_if.source chars
);
  import u8dec_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_move;
  dec_result_t       dec_res;
  logic              out_valid;
  char_beat_t        out_beat;

  assign s1_move     = s1_valid && (!out_valid || chars.ready);
  assign bytes.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.byte_value;
      s1_last <= bytes.last_byte;
    end
  end

  u8dec_decode u_dec (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_move),
    .byte_value (s1_byte),
    .last_byte  (s1_last),
    .res        (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= dec_res.valid;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && dec_res.valid) begin
      out_beat <= dec_res.beat;
    end
  end

  assign chars.valid      = out_valid;
  assign chars.code_point = out_beat.code_point;
  assign chars.has_char   = out_beat.has_char;
  assign chars.string_end = out_beat.string_end;

endmodule
